@@ src/btt_pkg.sv @@
// shared types, function codes and helpers for the byte taint tag tracker
`timescale 1ns / 1ps

package btt_pkg;

  // function codes of a request
  localparam logic [3:0] FN_CLEAR      = 4'd0;
  localparam logic [3:0] FN_MEM_RD     = 4'd1;
  localparam logic [3:0] FN_MEM_WR     = 4'd2;
  localparam logic [3:0] FN_REG_RD     = 4'd3;
  localparam logic [3:0] FN_REG_WR     = 4'd4;
  localparam logic [3:0] FN_OPEN       = 4'd5;
  localparam logic [3:0] FN_CLOSE      = 4'd6;
  localparam logic [3:0] FN_READ_DONE  = 4'd7;
  localparam logic [3:0] FN_WRITE_CHK  = 4'd8;

  // tags are packed 32 to a memory word
  localparam int WORD_BITS = 32;
  localparam int WORD_LSB  = 5;

  // classified request as it sits in the queue; slots already reduced
  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] address;
    logic [15:0] length;
    logic [7:0]  reg_index;
    logic [7:0]  fd;
    logic        confidential;
    logic        external;
  } cmd_t;

  // value modulo slots for slots of at least 8: quotient fits in five bits
  function automatic logic [7:0] slot_mod(input logic [7:0] value, input int unsigned slots);
    logic [16:0] rem;
    logic [16:0] step;
    int unsigned k;
    rem = {9'd0, value};
    for (k = 5; k > 0; k--) begin
      step = 17'(slots << (k - 1));
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[7:0];
  endfunction

endpackage

@@ src/btt_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module btt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/btt_front.sv @@
// front end: accepts requests, reduces slot numbers and queues them
`timescale 1ns / 1ps

module btt_front #(
  parameter int REG_SLOTS = 256,
  parameter int FD_SLOTS  = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [3:0]     in_func,
  input  logic [15:0]    in_address,
  input  logic [15:0]    in_length,
  input  logic [7:0]     in_reg_index,
  input  logic [7:0]     in_fd,
  input  logic           in_confidential,
  input  logic           in_external,
  input  logic           clearing,
  input  logic           q_pop,
  output logic           q_valid,
  output btt_pkg::cmd_t  q_head
);

  btt_pkg::cmd_t q_mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push;
  logic          pop;
  btt_pkg::cmd_t cmd;

  // classify the incoming request
  always_comb begin
    cmd.func         = in_func;
    cmd.address      = in_address;
    cmd.length       = in_length;
    cmd.reg_index    = btt_pkg::slot_mod(in_reg_index, REG_SLOTS);
    cmd.fd           = btt_pkg::slot_mod(in_fd, FD_SLOTS);
    cmd.confidential = in_confidential;
    cmd.external     = in_external;
  end

  assign in_stall = clearing || (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_mem_r[rd_ptr_r];

  // two entry queue between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        q_mem_r[wr_ptr_r] <= cmd;
        wr_ptr_r          <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/btt_back.sv @@
// back end: executes queued requests against the tag, register and descriptor stores
`timescale 1ns / 1ps

module btt_back #(
  parameter int TAG_ADDR_BITS = 16,
  parameter int REG_SLOTS     = 256,
  parameter int FD_SLOTS      = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          clearing,
  input  logic          q_valid,
  input  btt_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_allowed,
  output logic          out_taint_flag
);

  localparam int WAB       = TAG_ADDR_BITS - btt_pkg::WORD_LSB;
  localparam int TAG_WORDS = 1 << WAB;
  localparam int REG_W     = $clog2(REG_SLOTS);
  localparam int FD_W      = $clog2(FD_SLOTS);
  localparam int MAX_A     = (TAG_WORDS > REG_SLOTS) ? TAG_WORDS : REG_SLOTS;
  localparam int CLR_DEPTH = (MAX_A > FD_SLOTS) ? MAX_A : FD_SLOTS;
  localparam int CW        = $clog2(CLR_DEPTH + 1);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_DEPTH - 1);
  localparam logic [CW-1:0] TAG_LAST = CW'(TAG_WORDS - 1);
  localparam logic [CW-1:0] REG_LAST = CW'(REG_SLOTS - 1);
  localparam logic [CW-1:0] FD_LAST  = CW'(FD_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_REGW, S_FDW, S_WRD, S_WDO, S_DONE
  } state_t;

  state_t                   st_r;
  logic [CW-1:0]            clr_cnt_r;
  logic [3:0]               func_r;
  logic [TAG_ADDR_BITS-1:0] cur_r;
  logic [15:0]              rem_r;
  logic [FD_W-1:0]          fd_r;
  logic                     conf_r;
  logic                     ext_r;
  logic                     flag_r;
  logic                     allowed_r;
  logic                     out_valid_r;
  logic                     out_allowed_r;
  logic                     out_taint_flag_r;

  logic [btt_pkg::WORD_LSB-1:0] off;
  logic [6:0]                   avail;
  logic [6:0]                   take;
  logic [btt_pkg::WORD_BITS-1:0] mask;
  logic                         last_word;
  logic                         fill;
  logic                         fill_val;
  logic                         hit;

  logic                          tag_we;
  logic [WAB-1:0]                tag_waddr;
  logic [btt_pkg::WORD_BITS-1:0] tag_wdata;
  logic [WAB-1:0]                tag_raddr;
  logic [btt_pkg::WORD_BITS-1:0] tag_rdata;
  logic                          reg_we;
  logic [REG_W-1:0]              reg_waddr;
  logic                          reg_wdata;
  logic [REG_W-1:0]              reg_raddr;
  logic                          reg_rdata;
  logic                          fd_we;
  logic [FD_W-1:0]               fd_waddr;
  logic [1:0]                    fd_wdata;
  logic [FD_W-1:0]               fd_raddr;
  logic [1:0]                    fd_rdata;
  logic                          head_go;

  assign clearing = (st_r == S_CLEAR);
  assign q_pop    = (st_r == S_IDLE);
  assign head_go  = (st_r == S_IDLE) && q_valid;

  // part of the current range that falls in the current tag word
  always_comb begin
    off   = cur_r[btt_pkg::WORD_LSB-1:0];
    avail = 7'(btt_pkg::WORD_BITS) - {2'b00, off};
    take  = (rem_r < 16'(avail)) ? rem_r[6:0] : avail;
    for (int i = 0; i < btt_pkg::WORD_BITS; i++) begin
      mask[i] = (7'(i) >= {2'b00, off}) && (7'(i) < ({2'b00, off} + take));
    end
    last_word = (rem_r == 16'(take));
    fill      = (func_r == btt_pkg::FN_MEM_WR) || (func_r == btt_pkg::FN_READ_DONE);
    fill_val  = (func_r == btt_pkg::FN_MEM_WR) ? flag_r : 1'b1;
    hit       = |(tag_rdata & mask);
  end

  // tag store port control, clearing pass has priority
  always_comb begin
    tag_raddr = cur_r[TAG_ADDR_BITS-1:btt_pkg::WORD_LSB];
    if (clearing) begin
      tag_we    = (clr_cnt_r <= TAG_LAST);
      tag_waddr = clr_cnt_r[WAB-1:0];
      tag_wdata = '0;
    end else begin
      tag_we    = (st_r == S_WDO) && fill;
      tag_waddr = cur_r[TAG_ADDR_BITS-1:btt_pkg::WORD_LSB];
      tag_wdata = fill_val ? (tag_rdata | mask) : (tag_rdata & ~mask);
    end
  end

  // register tag port control
  always_comb begin
    reg_raddr = REG_W'(q_head.reg_index);
    if (clearing) begin
      reg_we    = (clr_cnt_r <= REG_LAST);
      reg_waddr = clr_cnt_r[REG_W-1:0];
      reg_wdata = 1'b0;
    end else begin
      reg_we    = head_go && (q_head.func == btt_pkg::FN_REG_WR);
      reg_waddr = REG_W'(q_head.reg_index);
      reg_wdata = flag_r;
    end
  end

  // descriptor flag port control, bit 0 source and bit 1 sink
  always_comb begin
    fd_raddr = FD_W'(q_head.fd);
    if (clearing) begin
      fd_we    = (clr_cnt_r <= FD_LAST);
      fd_waddr = clr_cnt_r[FD_W-1:0];
      fd_wdata = 2'b00;
    end else if (st_r == S_FDW) begin
      fd_we    = (func_r == btt_pkg::FN_OPEN);
      fd_waddr = fd_r;
      fd_wdata = fd_rdata | {ext_r, conf_r};
    end else begin
      fd_we    = head_go && (q_head.func == btt_pkg::FN_CLOSE);
      fd_waddr = FD_W'(q_head.fd);
      fd_wdata = 2'b00;
    end
  end

  btt_ram #(.WIDTH(btt_pkg::WORD_BITS), .DEPTH(TAG_WORDS)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  btt_ram #(.WIDTH(1), .DEPTH(REG_SLOTS)) u_reg_ram (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );

  btt_ram #(.WIDTH(2), .DEPTH(FD_SLOTS)) u_fd_ram (
    .clk(clk), .we(fd_we), .waddr(fd_waddr), .wdata(fd_wdata),
    .raddr(fd_raddr), .rdata(fd_rdata)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_cnt_r   <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid_r && !out_stall && (st_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + CW'(1);
          if (clr_cnt_r == CLR_LAST) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            func_r    <= q_head.func;
            cur_r     <= TAG_ADDR_BITS'(q_head.address);
            rem_r     <= q_head.length;
            fd_r      <= FD_W'(q_head.fd);
            conf_r    <= q_head.confidential;
            ext_r     <= q_head.external;
            allowed_r <= 1'b1;
            unique case (q_head.func) inside
              btt_pkg::FN_CLEAR: begin
                flag_r <= 1'b0;
                st_r   <= S_DONE;
              end
              btt_pkg::FN_MEM_RD, btt_pkg::FN_MEM_WR: begin
                st_r <= (q_head.length == 16'd0) ? S_DONE : S_WRD;
              end
              btt_pkg::FN_REG_RD: st_r <= S_REGW;
              btt_pkg::FN_OPEN, btt_pkg::FN_READ_DONE, btt_pkg::FN_WRITE_CHK: st_r <= S_FDW;
              default: st_r <= S_DONE;
            endcase
          end
        end
        S_REGW: begin
          flag_r <= flag_r | reg_rdata;
          st_r   <= S_DONE;
        end
        S_FDW: begin
          if (func_r == btt_pkg::FN_READ_DONE) begin
            st_r <= (fd_rdata[0] && rem_r != 16'd0) ? S_WRD : S_DONE;
          end else if (func_r == btt_pkg::FN_WRITE_CHK) begin
            st_r <= (fd_rdata[1] && rem_r != 16'd0) ? S_WRD : S_DONE;
          end else begin
            st_r <= S_DONE;
          end
        end
        S_WRD: st_r <= S_WDO;
        S_WDO: begin
          if (!fill && hit) begin
            if (func_r == btt_pkg::FN_MEM_RD) begin
              flag_r <= 1'b1;
            end else begin
              allowed_r <= 1'b0;
            end
            st_r <= S_DONE;
          end else begin
            cur_r <= cur_r + TAG_ADDR_BITS'(take);
            rem_r <= rem_r - 16'(take);
            st_r  <= last_word ? S_DONE : S_WRD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r      <= 1'b1;
            out_allowed_r    <= allowed_r;
            out_taint_flag_r <= flag_r;
            st_r             <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_allowed    = out_allowed_r;
  assign out_taint_flag = out_taint_flag_r;

endmodule

@@ src/byte_taint_tag_tracker.sv @@
// Byte taint tag tracker: one taint tag per byte of a 2^TAG_ADDR_BITS tag store, packed 32 to a
// ram word, plus register tags, descriptor source and sink flags and a current taint flag. After
// reset a clearing pass zeroes all stores, one word of each per cycle, over
// max(2^(TAG_ADDR_BITS-5), REG_SLOTS, FD_SLOTS) addresses; in_stall stays high
// meanwhile. Requests go through a two entry queue to a sequencer that handles one at a time:
// flag clear, register write, close and unused codes go straight to the result; register read
// and open first read their store; a memory read or write reads and then checks or writes each
// tag word it touches, and a read done or write check reads the source or sink flag first and
// walks the words only if it is set; a scan stops at the first tainted word. A stalled result
// holds the sequencer in its last step. Each request gives exactly one result.
`timescale 1ns / 1ps

module byte_taint_tag_tracker #(
  parameter int TAG_ADDR_BITS = 16,
  parameter int REG_SLOTS     = 256,
  parameter int FD_SLOTS      = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_func,
  input  logic [15:0] in_address,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_reg_index,
  input  logic [7:0]  in_fd,
  input  logic        in_confidential,
  input  logic        in_external,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_allowed,
  output logic        out_taint_flag
);

  logic          clearing;
  logic          q_valid;
  logic          q_pop;
  btt_pkg::cmd_t q_head;

  // request intake and queue
  btt_front #(.REG_SLOTS(REG_SLOTS), .FD_SLOTS(FD_SLOTS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_address(in_address), .in_length(in_length),
    .in_reg_index(in_reg_index), .in_fd(in_fd),
    .in_confidential(in_confidential), .in_external(in_external),
    .clearing(clearing), .q_pop(q_pop), .q_valid(q_valid), .q_head(q_head)
  );

  // execution against the stores
  btt_back #(
    .TAG_ADDR_BITS(TAG_ADDR_BITS), .REG_SLOTS(REG_SLOTS), .FD_SLOTS(FD_SLOTS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .clearing(clearing),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_allowed(out_allowed), .out_taint_flag(out_taint_flag)
  );

endmodule

@@ src/btt_checker.sv @@
// port level checks for the byte taint tag tracker
`timescale 1ns / 1ps

module btt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // a result waiting on the consumer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");

  // a stalled request stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("request dropped while stalled");

  // clearing pass keeps requests out right after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> in_stall) else $error("request taken during clearing pass");

  // no result appears straight out of reset
  a_no_early_out: assert property (@(posedge clk)
    $rose(out_valid) |-> $past(rst_n)) else $error("result right after reset");

  // reset empties the result register
  a_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");

endmodule

bind byte_taint_tag_tracker btt_checker u_btt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall)
);
